// ===== design/vss_pkg.sv =====
// shared types and codes for the value search stack
package vss_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

// ===== design/vss_if.sv =====
// request and response channel interfaces of the value search stack
interface vss_req_if;
    import vss_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    word_t value;
    word_t new_value;

    modport source (output valid, output op, output value, output new_value, input ready);
    modport sink   (input valid, input op, input value, input new_value, output ready);
endinterface

interface vss_rsp_if;
    import vss_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    word_t   data;
    logic    last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== design/vss_mem.sv =====
// entry storage: one write port, one read port with registered read data
module vss_mem #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  vss_pkg::word_t            wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output vss_pkg::word_t            rd_data
);
    import vss_pkg::*;

    word_t mem_array [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_array[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/vss_ctrl.sv =====
// sequencer: push, drain, search, delete compaction and the response register
module vss_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    vss_req_if.sink                   req,
    vss_rsp_if.source                 rsp,
    output logic                      mem_we,
    output logic [$clog2(DEPTH)-1:0]  mem_waddr,
    output vss_pkg::word_t            mem_wdata,
    output logic                      mem_re,
    output logic [$clog2(DEPTH)-1:0]  mem_raddr,
    input  vss_pkg::word_t            mem_rd_data
);
    import vss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DRAIN  = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    op_t            op_reg, op_next;
    word_t          key_reg, key_next;
    word_t          nval_reg, nval_next;
    status_t        res_status_reg, res_status_next;
    word_t          res_data_reg, res_data_next;

    logic           ovalid_reg, ovalid_next;
    status_t        ostatus_reg, ostatus_next;
    word_t          odata_reg, odata_next;
    logic           olast_reg, olast_next;

    logic           req_acc;
    logic           out_free;
    logic [CW-1:0]  cnt_m1, cnt_m2;
    logic [AW-1:0]  ptr_m1;
    logic [EW-1:0]  cnt_w, ptr_p1_w, ptr_p2_w;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign out_free   = !ovalid_reg || rsp.ready;

    assign cnt_m1     = cnt_reg - CW'(1);
    assign cnt_m2     = cnt_reg - CW'(2);
    assign ptr_m1     = ptr_reg - AW'(1);
    assign cnt_w      = EW'(cnt_reg);
    assign ptr_p1_w   = EW'(ptr_reg) + EW'(1);
    assign ptr_p2_w   = EW'(ptr_reg) + EW'(2);

    assign rsp.valid  = ovalid_reg;
    assign rsp.status = ostatus_reg;
    assign rsp.data   = odata_reg;
    assign rsp.last   = olast_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        nval_next       = nval_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;

        ovalid_next     = ovalid_reg && !rsp.ready;
        ostatus_next    = ostatus_reg;
        odata_next      = odata_reg;
        olast_next      = olast_reg;

        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = nval_reg;
        mem_re          = 1'b0;
        mem_raddr       = cnt_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    op_next       = req.op;
                    key_next      = req.value;
                    nval_next     = req.new_value;
                    res_data_next = '0;
                    unique case (req.op)
                        OP_PUSH:
                        begin
                            state_next = S_FINISH;
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = cnt_reg[AW-1:0];
                                mem_wdata       = req.value;
                                cnt_next        = cnt_reg + CW'(1);
                                res_status_next = ST_OK;
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_DRAIN;
                            end
                        end
                        OP_UPDATE, OP_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = (req.op == OP_UPDATE) ? ST_NOT_FOUND
                                                                        : ST_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                // scan starts at the top entry
                                mem_re     = 1'b1;
                                ptr_next   = cnt_m1[AW-1:0];
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DRAIN:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = ST_OK;
                    odata_next   = mem_rd_data;
                    olast_next   = (cnt_reg == CW'(1));
                    cnt_next     = cnt_m1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cnt_m2[AW-1:0];
                    end
                end
            end

            S_SEARCH:
            begin
                if (mem_rd_data == key_reg)
                begin
                    res_status_next = ST_OK;
                    if (op_reg == OP_UPDATE)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = ptr_reg;
                        mem_wdata  = nval_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        res_data_next = mem_rd_data;
                        if (ptr_p1_w < cnt_w)
                        begin
                            // entries above the hole move down one slot
                            mem_re     = 1'b1;
                            mem_raddr  = ptr_p1_w[AW-1:0];
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            cnt_next   = cnt_m1;
                            state_next = S_FINISH;
                        end
                    end
                end
                else if (ptr_reg == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_m1;
                    ptr_next  = ptr_m1;
                end
            end

            S_SHIFT:
            begin
                // write slot ptr while the entry two above is read
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rd_data;
                if (ptr_p2_w < cnt_w)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p2_w[AW-1:0];
                    ptr_next  = ptr_p1_w[AW-1:0];
                end
                else
                begin
                    cnt_next   = cnt_m1;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = res_status_reg;
                    odata_next   = res_data_reg;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        nval_reg       <= nval_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        ostatus_reg    <= ostatus_next;
        odata_reg      <= odata_next;
        olast_reg      <= olast_next;
    end

endmodule

// ===== design/value_search_stack_unit.sv =====
// top level of the value search stack: sequencer plus entry memory
//
//  channel | dir | beat fields                | accepted when
//  req     | in  | op, value, new_value       | req.valid && req.ready
//  rsp     | out | status, data, last         | rsp.valid && rsp.ready
//
// push writes the next free slot with no scan; update scans k entries
// from the top (at most fill_count), one per memory read
// delete compacts by moving each entry above the match down one slot through the write port
// drain of n entries gives one beat per cycle while rsp is ready, after the first read
// reset clears the fill count and the response valid flag; entries are not cleared
// a stalled rsp holds one finished beat while the next request is taken
module value_search_stack_unit #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    vss_req_if.sink   req,
    vss_rsp_if.source rsp
);
    import vss_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    word_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    word_t         mem_rd_data;

    vss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rd_data (mem_rd_data)
    );

    vss_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (mem_rd_data)
    );

endmodule
